### hdl/assert_macros.svh
// Assertion macros used by the checker file of the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst
`define AST_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, clocked on clk, off during rst
`define AST_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### hdl/mbm_pkg.sv
// Types, constants and fixed-point helpers of the Mandelbrot membership block
package mbm_pkg;

  localparam int FRAC_BITS  = 44;
  localparam int COORD_BITS = 12;
  localparam int VAL_W      = FRAC_BITS + 4;   // Q4.F
  localparam int Q8_W       = FRAC_BITS + 8;   // Q8.F, signed
  localparam int DIM_W      = COORD_BITS + 1;
  localparam int D_W        = COORD_BITS + 2;  // signed pixel offset
  localparam int ITER_W     = 16;
  localparam int HALF_W     = (Q8_W + 1) / 2;  // multiplier operand slice
  localparam int PROD_W     = 2 * Q8_W;
  localparam int APB_DW     = 64;
  localparam int ADDR_W     = 6;
  localparam int REG_IDX_W  = 3;

  // Register indexes, at byte address 8*index
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_STEP = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_WIDTH      = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = REG_IDX_W'(5);

  // Reset values
  localparam logic [FRAC_BITS-1:0] STEP_RESET   = FRAC_BITS'(64'd78187493530);
  localparam logic [DIM_W-1:0]     WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0]     HEIGHT_RESET = DIM_W'(480);
  localparam logic [ITER_W-1:0]    LIMIT_RESET  = ITER_W'(1000);

  // Fixed-point constants in Q8.F
  localparam logic signed [Q8_W-1:0] LIM8 = {1'b0, {(Q8_W-1){1'b1}}};
  localparam logic signed [Q8_W-1:0] NLIM8 = -LIM8;
  localparam logic signed [Q8_W:0]   LIM8_X = {2'b00, {(Q8_W-1){1'b1}}};
  localparam logic signed [Q8_W:0]   NLIM8_X = -LIM8_X;
  localparam logic signed [Q8_W-1:0] ONE_FX =
    {{(Q8_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [Q8_W-1:0] QUARTER_FX   = ONE_FX >>> 2;
  localparam logic signed [Q8_W-1:0] SIXTEENTH_FX = ONE_FX >>> 4;
  localparam logic signed [Q8_W-1:0] TWO_FX       = ONE_FX <<< 1;
  localparam logic signed [Q8_W-1:0] NTWO_FX      = -TWO_FX;
  localparam logic signed [Q8_W-1:0] ESCAPE_FX    = ONE_FX <<< 4;
  localparam logic signed [Q8_W-1:0] Q4_HI =
    {{(Q8_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [Q8_W-1:0] Q4_LO =
    {{(Q8_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } pix_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_col;
    logic [COORD_BITS-1:0] out_row;
    logic                  member;
  } res_t;

  // Request to and answer from the shared multiplier
  typedef struct packed {
    logic                   start;
    logic                   shift_frac;  // 1: shift by F, 0: shift by 1
    logic signed [Q8_W-1:0] a;
    logic signed [Q8_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [Q8_W-1:0] res;
  } mul_rsp_t;

  // Add with saturation to the Q8.F magnitude limit
  function automatic logic signed [Q8_W-1:0] sat_add(input logic signed [Q8_W-1:0] a,
                                                     input logic signed [Q8_W-1:0] b);
    logic signed [Q8_W:0] s;
    s = {a[Q8_W-1], a} + {b[Q8_W-1], b};
    if (s > LIM8_X) begin
      return LIM8;
    end else if (s < NLIM8_X) begin
      return NLIM8;
    end
    return s[Q8_W-1:0];
  endfunction

  // Clamp a Q8.F value to the Q4.F range
  function automatic logic signed [VAL_W-1:0] q4_clamp(input logic signed [Q8_W-1:0] v);
    if (v > Q4_HI) begin
      return Q4_HI[VAL_W-1:0];
    end else if (v < Q4_LO) begin
      return Q4_LO[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

  // Magnitude of a signed Q8.F value
  function automatic logic [Q8_W-1:0] mag(input logic signed [Q8_W-1:0] v);
    return v[Q8_W-1] ? (Q8_W'(0) - v) : v;
  endfunction

endpackage

### hdl/mbm_mul.sv
// Multi-cycle signed multiplier with shift and saturation, built on one slice multiplier
module mbm_mul import mbm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_MAG  = 4'b0010,
    M_PP   = 4'b0100,
    M_FIN  = 4'b1000
  } mul_state_t;

  mul_state_t              mstate;
  logic signed [Q8_W-1:0]  ra, rb;
  logic                    sel;
  logic [Q8_W-1:0]         ua, ub;
  logic                    neg;
  logic [PROD_W-1:0]       acc;
  logic [1:0]              k;
  logic                    done;
  logic signed [Q8_W-1:0]  res;

  logic [2*HALF_W-1:0]     ua_ext, ub_ext;
  logic [HALF_W-1:0]       a_part, b_part;
  logic [2*HALF_W-1:0]     pp;
  logic [PROD_W-1:0]       pp_ext, pp_sh;
  logic [PROD_W-1:0]       shifted;
  logic [Q8_W-1:0]         r_mag;

  // Pick operand slices for this partial product
  always_comb begin
    ua_ext = {{(2*HALF_W-Q8_W){1'b0}}, ua};
    ub_ext = {{(2*HALF_W-Q8_W){1'b0}}, ub};
    a_part = k[1] ? ua_ext[2*HALF_W-1:HALF_W] : ua_ext[HALF_W-1:0];
    b_part = k[0] ? ub_ext[2*HALF_W-1:HALF_W] : ub_ext[HALF_W-1:0];
    pp     = (2*HALF_W)'(a_part) * (2*HALF_W)'(b_part);
    pp_ext = PROD_W'(pp);
    case (k)
      2'd0:    pp_sh = pp_ext;
      2'd3:    pp_sh = pp_ext << (2 * HALF_W);
      default: pp_sh = pp_ext << HALF_W;
    endcase
  end

  // Shift the exact product and saturate its magnitude
  always_comb begin
    shifted = sel ? (acc >> FRAC_BITS) : (acc >> 1);
    if (shifted > PROD_W'(LIM8)) begin
      r_mag = LIM8;
    end else begin
      r_mag = shifted[Q8_W-1:0];
    end
  end

  // Sequence the unit
  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (mstate)
        M_IDLE: begin
          if (req.start) mstate <= M_MAG;
        end
        M_MAG:  mstate <= M_PP;
        M_PP: begin
          if (k == 2'd3) mstate <= M_FIN;
        end
        M_FIN: begin
          mstate <= M_IDLE;
          done   <= 1'b1;
        end
        default: mstate <= M_IDLE;
      endcase
    end
  end

  // Capture operands, accumulate partial products, form the result
  always_ff @(posedge clk) begin
    case (mstate)
      M_IDLE: begin
        if (req.start) begin
          ra  <= req.a;
          rb  <= req.b;
          sel <= req.shift_frac;
        end
      end
      M_MAG: begin
        ua  <= mag(ra);
        ub  <= mag(rb);
        neg <= ra[Q8_W-1] ^ rb[Q8_W-1];
        acc <= '0;
        k   <= 2'd0;
      end
      M_PP: begin
        acc <= acc + pp_sh;
        k   <= k + 2'd1;
      end
      M_FIN: begin
        res <= neg ? (Q8_W'(0) - r_mag) : r_mag;
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

### hdl/mandelbrot_pixel_membership.sv
// Top level: pixel-to-plane mapping, early tests and escape-time loop on one shared multiplier
//
//   channel  direction  handshake              word
//   pix      in         pix_valid / pix_ready  col, row
//   res      out        res_valid / res_ready  out_col, out_row, member
//   apb      in/out     psel, penable, pready  64-bit registers at 8*index
//
// Every product goes through one multi-cycle multiplier (four 26x26 slice
// products). A pixel runs setup and early tests, then up to limit rounds of
// z = z^2 + c; early decisions finish sooner. One pixel is in work at a time.
// Reset (synchronous) loads the register defaults; no clearing pass.
// The result waits in an output register, so the next pixel is taken while a
// result stalls; a finished pixel holds until that register is free.
module mandelbrot_pixel_membership import mbm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  pix_t              pix,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_MX   = 15'h0002,
    S_MY   = 15'h0004,
    S_MXY  = 15'h0008,
    S_MT1  = 15'h0010,
    S_MYY  = 15'h0020,
    S_MT2  = 15'h0040,
    S_MXX  = 15'h0080,
    S_LCHK = 15'h0100,
    S_MZP  = 15'h0200,
    S_UPD1 = 15'h0400,
    S_UPD2 = 15'h0800,
    S_MZR  = 15'h1000,
    S_MZI  = 15'h2000,
    S_FIN  = 15'h4000
  } state_t;

  // Configuration registers
  logic signed [VAL_W-1:0] center_x, center_y;
  logic [FRAC_BITS-1:0]    pixel_step;
  logic [DIM_W-1:0]        image_width, image_height;
  logic [ITER_W-1:0]       iteration_limit;

  // Sequencer and working registers
  state_t                  state, state_next;
  logic                    go, go_next;
  logic                    member_r, member_next;
  logic [COORD_BITS-1:0]   col_r, row_r;
  logic signed [D_W-1:0]   dx, dy;
  logic signed [VAL_W-1:0] x, y;
  logic signed [Q8_W-1:0]  tt, yy, zr, zi, zr2, zi2, pr;
  logic [ITER_W-1:0]       iter;

  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    wr_en;
  logic                    out_load;

  mul_req_t                mreq;
  mul_rsp_t                mrsp;

  logic signed [Q8_W-1:0]  x_ext, y_ext, t1, t2, step_ext, dx_ext, dy_ext;
  logic signed [Q8_W-1:0]  chk_op, sum_chk, ctr_op;
  logic signed [VAL_W-1:0] coord_new;
  logic                    is_mul_next;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      pixel_step      <= STEP_RESET;
      image_width     <= WIDTH_RESET;
      image_height    <= HEIGHT_RESET;
      iteration_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CENTER_X:   center_x        <= pwdata[VAL_W-1:0];
        REG_CENTER_Y:   center_y        <= pwdata[VAL_W-1:0];
        REG_PIXEL_STEP: pixel_step      <= pwdata[FRAC_BITS-1:0];
        REG_WIDTH:      image_width     <= pwdata[DIM_W-1:0];
        REG_HEIGHT:     image_height    <= pwdata[DIM_W-1:0];
        REG_ITER_LIMIT: iteration_limit <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_X:   prdata = {{(APB_DW-VAL_W){1'b0}}, center_x};
      REG_CENTER_Y:   prdata = {{(APB_DW-VAL_W){1'b0}}, center_y};
      REG_PIXEL_STEP: prdata = {{(APB_DW-FRAC_BITS){1'b0}}, pixel_step};
      REG_WIDTH:      prdata = {{(APB_DW-DIM_W){1'b0}}, image_width};
      REG_HEIGHT:     prdata = {{(APB_DW-DIM_W){1'b0}}, image_height};
      REG_ITER_LIMIT: prdata = {{(APB_DW-ITER_W){1'b0}}, iteration_limit};
      default:        prdata = '0;
    endcase
  end

  // Operand forms
  assign x_ext    = {{(Q8_W-VAL_W){x[VAL_W-1]}}, x};
  assign y_ext    = {{(Q8_W-VAL_W){y[VAL_W-1]}}, y};
  assign t1       = sat_add(x_ext, QUARTER_FX);
  assign t2       = sat_add(x_ext, ONE_FX);
  assign step_ext = {{(Q8_W-FRAC_BITS){1'b0}}, pixel_step};
  assign dx_ext   = {{(Q8_W-D_W){dx[D_W-1]}}, dx};
  assign dy_ext   = {{(Q8_W-D_W){dy[D_W-1]}}, dy};

  // Route operands to the shared multiplier
  always_comb begin
    mreq.start      = go;
    mreq.shift_frac = 1'b1;
    mreq.a          = x_ext;
    mreq.b          = x_ext;
    case (state)
      S_MX: begin
        mreq.shift_frac = 1'b0;
        mreq.a          = step_ext;
        mreq.b          = dx_ext;
      end
      S_MY: begin
        mreq.shift_frac = 1'b0;
        mreq.a          = step_ext;
        mreq.b          = dy_ext;
      end
      S_MXY: mreq.b = y_ext;
      S_MT1: begin
        mreq.a = t1;
        mreq.b = t1;
      end
      S_MYY: begin
        mreq.a = y_ext;
        mreq.b = y_ext;
      end
      S_MT2: begin
        mreq.a = t2;
        mreq.b = t2;
      end
      S_MZP: begin
        mreq.a = zr;
        mreq.b = zi;
      end
      S_MZR: begin
        mreq.a = zr;
        mreq.b = zr;
      end
      S_MZI: begin
        mreq.a = zi;
        mreq.b = zi;
      end
      default: ;
    endcase
  end

  mbm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // Shared check sum and coordinate update
  always_comb begin
    case (state)
      S_MYY:   chk_op = tt;
      S_MT2:   chk_op = yy;
      default: chk_op = zr2;
    endcase
    sum_chk   = sat_add(chk_op, mrsp.res);
    ctr_op    = (state == S_MY) ? {{(Q8_W-VAL_W){center_y[VAL_W-1]}}, center_y}
                                : {{(Q8_W-VAL_W){center_x[VAL_W-1]}}, center_x};
    coord_new = q4_clamp(sat_add(ctr_op, mrsp.res));
  end

  assign out_load = (state == S_FIN) && (!res_valid || res_ready);

  // Next state and decision
  always_comb begin
    state_next  = state;
    member_next = member_r;
    case (state)
      S_IDLE: begin
        if (pix_valid) state_next = S_MX;
      end
      S_MX: begin
        if (mrsp.done) state_next = S_MY;
      end
      S_MY: begin
        if (mrsp.done) state_next = S_MXY;
      end
      S_MXY: begin
        if (mrsp.done) begin
          if ((mrsp.res > TWO_FX) || (mrsp.res < NTWO_FX)) begin
            member_next = 1'b0;
            state_next  = S_FIN;
          end else begin
            state_next = S_MT1;
          end
        end
      end
      S_MT1: begin
        if (mrsp.done) state_next = S_MYY;
      end
      S_MYY: begin
        if (mrsp.done) begin
          if (sum_chk < QUARTER_FX) begin
            member_next = 1'b1;
            state_next  = S_FIN;
          end else begin
            state_next = S_MT2;
          end
        end
      end
      S_MT2: begin
        if (mrsp.done) begin
          if (sum_chk < SIXTEENTH_FX) begin
            member_next = 1'b1;
            state_next  = S_FIN;
          end else begin
            state_next = S_MXX;
          end
        end
      end
      S_MXX: begin
        if (mrsp.done) state_next = S_LCHK;
      end
      S_LCHK: begin
        if (iter < iteration_limit) begin
          state_next = S_MZP;
        end else begin
          member_next = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_MZP: begin
        if (mrsp.done) state_next = S_UPD1;
      end
      S_UPD1: state_next = S_UPD2;
      S_UPD2: state_next = S_MZR;
      S_MZR: begin
        if (mrsp.done) state_next = S_MZI;
      end
      S_MZI: begin
        if (mrsp.done) begin
          if (sum_chk > ESCAPE_FX) begin
            member_next = 1'b0;
            state_next  = S_FIN;
          end else begin
            state_next = S_LCHK;
          end
        end
      end
      S_FIN: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Issue a multiply on entry to a multiply state
  always_comb begin
    is_mul_next = state_next inside {S_MX, S_MY, S_MXY, S_MT1, S_MYY, S_MT2, S_MXX,
                                     S_MZP, S_MZR, S_MZI};
    go_next     = is_mul_next && (state_next != state);
  end

  assign pix_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      go        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      go    <= go_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    member_r <= member_next;
    if (out_load) begin
      res.out_col <= col_r;
      res.out_row <= row_r;
      res.member  <= member_r;
    end
    case (state)
      S_IDLE: begin
        if (pix_valid) begin
          col_r <= pix.col;
          row_r <= pix.row;
          dx    <= {1'b0, pix.col, 1'b0} - {1'b0, image_width};
          dy    <= {1'b0, image_height} - {1'b0, pix.row, 1'b0};
        end
      end
      S_MX: begin
        if (mrsp.done) x <= coord_new;
      end
      S_MY: begin
        if (mrsp.done) y <= coord_new;
      end
      S_MT1: begin
        if (mrsp.done) tt <= mrsp.res;
      end
      S_MYY: begin
        if (mrsp.done) yy <= mrsp.res;
      end
      S_MXX: begin
        if (mrsp.done) begin
          zr2  <= mrsp.res;
          zi2  <= yy;
          zr   <= x_ext;
          zi   <= y_ext;
          iter <= '0;
        end
      end
      S_MZP: begin
        if (mrsp.done) pr <= mrsp.res;
      end
      // Real part difference and doubled cross term
      S_UPD1: begin
        zr2 <= sat_add(zr2, Q8_W'(0) - zi2);
        pr  <= sat_add(pr, pr);
      end
      // Add c to form the new z
      S_UPD2: begin
        zr <= sat_add(zr2, x_ext);
        zi <= sat_add(pr, y_ext);
      end
      S_MZR: begin
        if (mrsp.done) zr2 <= mrsp.res;
      end
      S_MZI: begin
        if (mrsp.done) begin
          zi2  <= mrsp.res;
          iter <= iter + ITER_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

### hdl/mbm_checker.sv
// Port-level checker for the Mandelbrot membership block, with its bind
`include "assert_macros.svh"

module mbm_checker import mbm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic pix_valid,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready,
  input res_t res,
  input logic pready
);

  // Hold a stalled result word
  `AST_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

  // Drop ready once a pixel is taken
  `AST_NEXT(a_busy_after_take, pix_valid && pix_ready, !pix_ready)

  // Never raise a result right after taking a pixel
  `AST_NEXT(a_no_instant_result, pix_valid && pix_ready, !$rose(res_valid))

  // Come out of reset with no result pending and the port ready
  `AST_IMPL(a_reset_clean, $past(rst), !res_valid && pready)

endmodule

bind mandelbrot_pixel_membership mbm_checker u_mbm_checker (.*);

### sim/tb_mandelbrot_pixel_membership.sv
// Testbench for the Mandelbrot pixel membership block: fixed-point predictor, scoreboard, drivers
`timescale 1ns / 100ps

module tb_mandelbrot_pixel_membership import mbm_pkg::*;;

  // Fixed-point limits, as plain integers
  localparam longint FX_ONE   = longint'(1) <<< FRAC_BITS;
  localparam longint MAG_CAP  = (longint'(1) <<< (FRAC_BITS + 7)) - 1;
  localparam longint Q4_TOP   = (longint'(1) <<< (FRAC_BITS + 3)) - 1;
  localparam longint Q4_BOT   = -Q4_TOP - 1;
  localparam longint STEP_TOP = (longint'(1) <<< FRAC_BITS) - 1;

  // Register slots that decode to nothing
  localparam int REG_UNUSED_LO = 6;
  localparam int REG_UNUSED_HI = 7;

  // Timing figures for the run budget
  localparam int ROUND_CYCLES = 27;
  localparam int SETUP_CYCLES = 100;
  localparam int MAX_GAP      = 20;
  localparam int MAX_STALL    = 30;
  localparam int SETTLE       = 8;

  // Predicted verdicts in arrival order, with a private copy of the registers
  class membership_board;
    longint center_x, center_y, pixel_step, width, height, limit;
    res_t   verdicts[$];
    int     errors, judged, members;

    function new();
      center_x   = 0;
      center_y   = 0;
      pixel_step = longint'(STEP_RESET);
      width      = 640;
      height     = 480;
      limit      = 1000;
      errors     = 0;
      judged     = 0;
      members    = 0;
    endfunction

    // Mirror a register write; only the low field bits count
    function void set_reg(int idx, logic [63:0] v);
      case (idx)
        REG_CENTER_X:   center_x   = longint'($signed(v[VAL_W-1:0]));
        REG_CENTER_Y:   center_y   = longint'($signed(v[VAL_W-1:0]));
        REG_PIXEL_STEP: pixel_step = longint'(v[FRAC_BITS-1:0]);
        REG_WIDTH:      width      = longint'(v[DIM_W-1:0]);
        REG_HEIGHT:     height     = longint'(v[DIM_W-1:0]);
        REG_ITER_LIMIT: limit      = longint'(v[ITER_W-1:0]);
        default: ;
      endcase
    endfunction

    // Exact product, magnitude shifted right, capped at the Q8 limit
    function longint scaled_product(longint a, longint b, int sh);
      logic [63:0]  ua, ub;
      logic [127:0] full, r;
      longint       m;
      ua = (a < 0) ? 64'(-a) : 64'(a);
      ub = (b < 0) ? 64'(-b) : 64'(b);
      full = {64'd0, ua} * {64'd0, ub};
      r = full >> sh;
      if (r > 128'(MAG_CAP)) r = 128'(MAG_CAP);
      m = longint'(r[63:0]);
      return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function longint add_sat(longint a, longint b);
      if (b > 0 && a > MAG_CAP - b) return MAG_CAP;
      if (b < 0 && a < -MAG_CAP - b) return -MAG_CAP;
      return a + b;
    endfunction

    function longint clamp_q4(longint v);
      if (v > Q4_TOP) return Q4_TOP;
      if (v < Q4_BOT) return Q4_BOT;
      return v;
    endfunction

    // Early rejection, cardioid and bulb tests, then the escape loop
    function bit judge_member(longint x, longint y);
      longint zr, zi, t, u, i;
      t = scaled_product(x, y, FRAC_BITS);
      if (((t < 0) ? -t : t) > 2 * FX_ONE) return 1'b0;
      t = add_sat(x, FX_ONE / 4);
      if (add_sat(scaled_product(t, t, FRAC_BITS), scaled_product(y, y, FRAC_BITS)) < FX_ONE / 4)
        return 1'b1;
      t = add_sat(x, FX_ONE);
      if (add_sat(scaled_product(t, t, FRAC_BITS), scaled_product(y, y, FRAC_BITS)) < FX_ONE / 16)
        return 1'b1;
      zr = x;
      zi = y;
      for (i = 0; i < limit; i++) begin
        t  = add_sat(add_sat(scaled_product(zr, zr, FRAC_BITS),
                             -scaled_product(zi, zi, FRAC_BITS)), x);
        u  = scaled_product(zr, zi, FRAC_BITS);
        zi = add_sat(add_sat(u, u), y);
        zr = t;
        if (add_sat(scaled_product(zi, zi, FRAC_BITS),
                    scaled_product(zr, zr, FRAC_BITS)) > 16 * FX_ONE)
          return 1'b0;
      end
      return 1'b1;
    endfunction

    // Map an accepted pixel to the plane and queue its verdict
    function void note_pixel(pix_t p);
      longint dx, dy, x, y;
      res_t   w;
      dx = 2 * longint'(p.col) - width;
      dy = height - 2 * longint'(p.row);
      x = clamp_q4(add_sat(center_x, scaled_product(pixel_step, dx, 1)));
      y = clamp_q4(add_sat(center_y, scaled_product(pixel_step, dy, 1)));
      w.out_col = p.col;
      w.out_row = p.row;
      w.member  = judge_member(x, y);
      verdicts.push_back(w);
    endfunction

    // Compare a result word with the oldest verdict
    function void check_result(res_t got);
      res_t w;
      if (verdicts.size() == 0) begin
        $error("result word (%0d,%0d) arrived with no verdict pending", got.out_col, got.out_row);
        errors++;
        return;
      end
      w = verdicts.pop_front();
      judged++;
      if (got.member) members++;
      if (got.out_col !== w.out_col) begin
        $error("out_col: expected %0d, actual %0d", w.out_col, got.out_col);
        errors++;
      end
      if (got.out_row !== w.out_row) begin
        $error("out_row: expected %0d, actual %0d", w.out_row, got.out_row);
        errors++;
      end
      if (got.member !== w.member) begin
        $error("member: expected %0d, actual %0d", w.member, got.member);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic              clk;
  logic              rst       = 1'b1;
  logic              pix_valid = 1'b0;
  logic              pix_ready;
  pix_t              pix       = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  res_t              res;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  membership_board board;
  longint          cycle_count  = 0;
  longint          cycle_budget = 5000;
  int              burst_left   = 0;
  int              ready_left   = 0;
  int              setting_count = 0;

  mandelbrot_pixel_membership uut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drop the run if the block stops answering
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Take result words and stall on a pattern of short and long stretches
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) board.check_result(res);
      if (ready_left > 0) begin
        ready_left--;
      end else if (res_ready) begin
        res_ready <= 1'b0;
        ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_STALL)
                                                  : $urandom_range(0, 3);
      end else begin
        res_ready <= 1'b1;
        ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400)
                                                  : $urandom_range(0, 30);
      end
    end
  end

  function automatic pix_t pixel(int c, int r);
    pix_t p;
    p.col = COORD_BITS'(c);
    p.row = COORD_BITS'(r);
    return p;
  endfunction

  // Write one register; bits above the field are sometimes filled with junk
  task automatic apb_write(input int idx, input logic [63:0] value, input int nbits);
    logic [63:0] keep, data;
    keep = (nbits >= 64) ? '1 : ((64'd1 << nbits) - 64'd1);
    data = value & keep;
    if ($urandom_range(0, 1) == 1) data = data | ({$urandom, $urandom} & ~keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, data);
    cycle_budget += 16;
    @(posedge clk);
  endtask

  task automatic apply_view(input longint cx, input longint cy, input longint step,
                            input longint w, input longint h, input longint lim);
    apb_write(REG_CENTER_X, cx, VAL_W);
    apb_write(REG_CENTER_Y, cy, VAL_W);
    apb_write(REG_PIXEL_STEP, step, FRAC_BITS);
    apb_write(REG_WIDTH, w, DIM_W);
    apb_write(REG_HEIGHT, h, DIM_W);
    apb_write(REG_ITER_LIMIT, lim, ITER_W);
    setting_count++;
  endtask

  // Offer one pixel word, in bursts with random gaps between them
  task automatic send_pixel(input pix_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap > 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_valid <= 1'b1;
    pix       <= p;
    cycle_budget += 4 * (ROUND_CYCLES * board.limit + SETUP_CYCLES + MAX_GAP + MAX_STALL);
    do @(posedge clk); while (!pix_ready);
    board.note_pixel(p);
  endtask

  // Hold off the sender until every verdict is matched, then settle
  task automatic wait_drained();
    pix_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    cycle_budget += SETTLE + 4;
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int     ph, wv, hv, tail;
    bit     noisy;
    longint step, cx, cy, lim;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset view: center, both bulbs, corners, far clamped corners
    send_pixel(pixel(320, 240));
    send_pixel(pixel(160, 240));
    send_pixel(pixel(96, 240));
    send_pixel(pixel(0, 0));
    send_pixel(pixel(639, 479));
    send_pixel(pixel(4095, 4095));
    send_pixel(pixel(0, 4095));
    send_pixel(pixel(4095, 0));

    // Largest round limit, only points decided early or escaping at once
    wait_drained();
    apply_view(0, 0, FX_ONE >>> 6, 8, 8, 65535);
    send_pixel(pixel(4, 4));
    send_pixel(pixel(0, 4));
    send_pixel(pixel(4095, 4));
    send_pixel(pixel(4095, 4095));

    // No rounds at all: undecided points count as members
    wait_drained();
    apply_view(0, 0, FX_ONE >>> 2, 8, 8, 0);
    send_pixel(pixel(8, 4));
    send_pixel(pixel(0, 0));
    send_pixel(pixel(15, 15));

    // Saturated centers, widest step, zero and oversized image sizes
    wait_drained();
    apply_view(Q4_TOP, 0, STEP_TOP, 8191, 0, 1);
    send_pixel(pixel(4095, 0));
    send_pixel(pixel(0, 0));
    send_pixel(pixel(4095, 1));
    wait_drained();
    apply_view(Q4_BOT, Q4_TOP, 0, 0, 8191, 2);
    send_pixel(pixel(0, 4095));
    send_pixel(pixel(4095, 0));

    // Writes to undecoded slots must change nothing
    wait_drained();
    apb_write(REG_UNUSED_LO, {$urandom, $urandom}, 64);
    apb_write(REG_UNUSED_HI, {$urandom, $urandom}, 64);

    // Random views over the set, with every fourth setting pure noise
    for (ph = 0; ph < 13; ph++) begin
      wait_drained();
      noisy = (ph % 4 == 3);
      wv = 1;
      hv = 1;
      if (noisy) begin
        apply_view({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom} >> $urandom_range(0, 40),
                   $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(1, 16));
      end else begin
        wv = ($urandom_range(0, 7) == 0) ? $urandom_range(97, 4096) : $urandom_range(1, 96);
        hv = ($urandom_range(0, 7) == 0) ? $urandom_range(97, 4096) : $urandom_range(1, 96);
        step = (FX_ONE * 7 / 2) / wv;
        step = step * $urandom_range(90, 110) / 100;
        if (step > STEP_TOP) step = STEP_TOP;
        cx = -(FX_ONE * 3 / 4) + ((longint'($urandom_range(0, 65535)) - 32768) <<< 28);
        cy = (longint'($urandom_range(0, 65535)) - 32768) <<< 28;
        lim = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 100) : $urandom_range(1, 24);
        apply_view(cx, cy, step, wv, hv, lim);
      end
      repeat (44) begin
        if (noisy || $urandom_range(0, 6) == 0)
          send_pixel(pixel($urandom_range(0, 4095), $urandom_range(0, 4095)));
        else
          send_pixel(pixel($urandom_range(0, wv - 1), $urandom_range(0, hv - 1)));
      end
    end

    // Drain, then watch for stray words over one pixel's latency
    wait_drained();
    tail = ROUND_CYCLES * int'(board.limit) + SETUP_CYCLES;
    if (tail > 4000) tail = 4000;
    cycle_budget += tail + 10;
    repeat (tail) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d verdicts never matched by a result word", board.pending());
      board.errors++;
    end

    $display("Judged %0d pixels (%0d in the set) over %0d register settings,",
             board.judged, board.members, setting_count);
    $display("including saturated centers, zero and maximal round limits and odd image sizes.");
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/mbm_pkg.sv
hdl/mbm_mul.sv
hdl/mandelbrot_pixel_membership.sv
hdl/mbm_checker.sv
sim/tb_mandelbrot_pixel_membership.sv
